// ===== hw/rtl/aes128rr_pkg.sv =====
// Shared types, constant tables and round functions for the reduced-round AES-128 pipeline.
`default_nettype none

package aes128rr_pkg;

  localparam int unsigned MaxRounds = 10;
  localparam int unsigned BlockW    = 128;

  // Forward S-box, element 0 first.
  localparam logic [0:255][7:0] SBOX = {
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // Round constants for rounds one through ten.
  localparam logic [0:MaxRounds-1][7:0] RCON = {
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam logic [7:0] GfPoly = 8'h1b;

  typedef struct packed {
    logic [BlockW-1:0] state;
    logic [BlockW-1:0] key;
  } stage_t;

  typedef struct packed {
    logic       apply;
    logic       mix;
    logic [7:0] rcon;
  } round_ctrl_t;

  typedef struct packed {
    logic [3:0] rounds;
    logic       final_mix;
  } cfg_t;

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? GfPoly : 8'h00);
  endfunction

  // Byte n of a block lives in bits 127-8n down to 120-8n.
  function automatic logic [BlockW-1:0] sub_shift(input logic [BlockW-1:0] s);
    logic [BlockW-1:0] t;
    int src;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = r + 4 * ((c + r) & 3);
        t[BlockW-1-8*(r+4*c) -: 8] = SBOX[s[BlockW-1-8*src -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3, all;
    a0  = w[31:24];
    a1  = w[23:16];
    a2  = w[15:8];
    a3  = w[7:0];
    all = a0 ^ a1 ^ a2 ^ a3;
    return {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
            a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
  endfunction

  function automatic logic [BlockW-1:0] mix_cols(input logic [BlockW-1:0] s);
    logic [BlockW-1:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      t[BlockW-1-32*c -: 32] = mix_col(s[BlockW-1-32*c -: 32]);
    end
    return t;
  endfunction

  // One step of the AES-128 key schedule, word by word.
  function automatic logic [BlockW-1:0] key_step(input logic [BlockW-1:0] k,
                                                 input logic [7:0] rcon);
    logic [31:0] w0, w1, w2, w3, rot;
    w0  = k[127:96];
    w1  = k[95:64];
    w2  = k[63:32];
    w3  = k[31:0];
    rot = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0  = w0 ^ rot;
    w1  = w1 ^ w0;
    w2  = w2 ^ w1;
    w3  = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/aes128rr_cfg.sv =====
// Configuration registers behind the APB-style port.
`default_nettype none

module aes128rr_cfg
  import aes128rr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  localparam logic RegRoundCount = 1'b0;
  localparam logic RegFinalMix   = 1'b1;

  logic [3:0] round_count_q, round_count_d;
  logic       final_mix_q, final_mix_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    round_count_d = round_count_q;
    final_mix_d   = final_mix_q;
    if (wr_en) begin
      case (paddr[2])
        RegRoundCount: round_count_d = pwdata[3:0];
        RegFinalMix:   final_mix_d   = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_count_q <= 4'(MaxRounds);
      final_mix_q   <= 1'b0;
    end else begin
      round_count_q <= round_count_d;
      final_mix_q   <= final_mix_d;
    end
  end

  always_comb begin
    case (paddr[2])
      RegRoundCount: prdata = {28'd0, round_count_q};
      RegFinalMix:   prdata = {31'd0, final_mix_q};
      default:       prdata = '0;
    endcase
  end

  // Zero rounds act as one, and anything past the last round saturates.
  always_comb begin
    if (round_count_q == 4'd0) begin
      cfg_o.rounds = 4'd1;
    end else if (round_count_q > 4'(MaxRounds)) begin
      cfg_o.rounds = 4'(MaxRounds);
    end else begin
      cfg_o.rounds = round_count_q;
    end
    cfg_o.final_mix = final_mix_q;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/aes128rr_round.sv =====
// One registered AES round stage with its key schedule step.
`default_nettype none

module aes128rr_round
  import aes128rr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire logic        valid_i,
  input  wire stage_t      data_i,
  input  wire round_ctrl_t ctrl_i,
  output logic             valid_o,
  output stage_t           data_o
);

  logic              valid_q;
  stage_t            data_q, data_d;
  logic [BlockW-1:0] key_next, sub_st, mix_st;

  always_comb begin
    key_next = key_step(data_i.key, ctrl_i.rcon);
    sub_st   = sub_shift(data_i.state);
    mix_st   = ctrl_i.mix ? mix_cols(sub_st) : sub_st;
    if (ctrl_i.apply) begin
      data_d.state = mix_st ^ key_next;
      data_d.key   = key_next;
    end else begin
      data_d = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/aes128_reduced_round_encrypt.sv =====
// A block accepted passes through the input register and then the round stages to the output.
// One block per cycle while the output is not stalled; every round has a register stage of its own.
// Stages past the configured round count pass the block through unchanged.
// Bubbles close up, so a new block is taken while a finished one waits.
// Reset clears every valid bit and sets ten rounds with a standard last round.
`default_nettype none

module aes128_reduced_round_encrypt
  import aes128rr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Plaintext and key channel.
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] block_hi_i,
  input  wire logic [63:0] block_lo_i,
  input  wire logic [63:0] key_hi_i,
  input  wire logic [63:0] key_lo_i,
  // Ciphertext channel.
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [63:0] cipher_hi_o,
  output logic      [63:0] cipher_lo_o,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  cfg_t cfg;

  aes128rr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Stage zero holds the whitened block; stages one through ten are the rounds.
  logic   [MaxRounds:0]   stage_valid;
  stage_t                 stage_data [MaxRounds+1];
  logic   [MaxRounds+1:0] advance;
  logic                   in_valid_q;
  stage_t                 in_data_q;

  // A stage may load when it is empty or when the stage after it moves on.
  // The output beat leaves once the consumer stops stalling.
  always_comb begin
    advance[MaxRounds+1] = !stage_valid[MaxRounds] || !out_stall_i;
    for (int j = int'(MaxRounds); j >= 0; j--) begin
      advance[j] = !stage_valid[j] || advance[j+1];
    end
  end

  assign in_stall_o = !advance[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (advance[0]) begin
      in_valid_q <= in_valid_i;
    end
  end

  // The initial key addition is only an XOR, so it rides on the input register.
  always_ff @(posedge clk_i) begin
    if (advance[0] && in_valid_i) begin
      in_data_q.state <= {block_hi_i, block_lo_i} ^ {key_hi_i, key_lo_i};
      in_data_q.key   <= {key_hi_i, key_lo_i};
    end
  end

  assign stage_valid[0] = in_valid_q;
  assign stage_data[0]  = in_data_q;

  for (genvar j = 1; j <= MaxRounds; j++) begin : g_round
    round_ctrl_t ctrl;

    // The user must change the configuration only while the pipeline is empty; the block
    // itself does not enforce this. Each stage reads the configuration directly. The last
    // active round skips MixColumns unless the final-mix mode is set.
    assign ctrl.apply = (4'(j) <= cfg.rounds);
    assign ctrl.mix   = (4'(j) < cfg.rounds) || cfg.final_mix;
    assign ctrl.rcon  = RCON[j-1];

    aes128rr_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .load_i  (advance[j]),
      .valid_i (stage_valid[j-1]),
      .data_i  (stage_data[j-1]),
      .ctrl_i  (ctrl),
      .valid_o (stage_valid[j]),
      .data_o  (stage_data[j])
    );
  end

  assign out_valid_o = stage_valid[MaxRounds];
  assign cipher_hi_o = stage_data[MaxRounds].state[127:64];
  assign cipher_lo_o = stage_data[MaxRounds].state[63:0];

endmodule

`default_nettype wire

// ===== hw/rtl/aes128rr_checker.sv =====
// Port-level assertions for the reduced-round AES pipeline and their bind.
`default_nettype none

module aes128rr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [63:0] cipher_hi_o,
  input wire logic [63:0] cipher_lo_o
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output beat shown during reset");

  // The input side only backs up when every stage is full and the output is held.
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the pipeline has room");

  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(cipher_hi_o) && $stable(cipher_lo_o)))
    else $error("output payload changed while stalled");

endmodule

bind aes128_reduced_round_encrypt aes128rr_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .cipher_hi_o (cipher_hi_o),
  .cipher_lo_o (cipher_lo_o)
);

`default_nettype wire
